// File: rtl/rbf_pkg.sv
`default_nettype none

package rbf_pkg;

	localparam int MAX_CENTERS_DEF     = 64;
	localparam int MAX_DIMENSION_DEF   = 16;
	localparam int EXP_TABLE_DEPTH_DEF = 256;

	localparam int VALUE_W = 16;
	localparam int CI_W    = 6;
	localparam int DI_W    = 4;
	localparam int NCFG_W  = 7;
	localparam int DCFG_W  = 5;
	localparam int INV_W   = 24;
	localparam int RESP_W  = 17;
	localparam int PRED_W  = 32;
	localparam int DIV_STEPS = 24;

	localparam logic [1:0] OP_CENTER = 2'd0;
	localparam logic [1:0] OP_RADIUS = 2'd1;
	localparam logic [1:0] OP_WEIGHT = 2'd2;
	localparam logic [1:0] OP_POINT  = 2'd3;

	localparam logic [0:0] REG_CENTERS   = 1'b0;
	localparam logic [0:0] REG_DIMENSION = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_DIV,
		ST_INV,
		ST_EVAL,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;       // input transfer this cycle
		logic sq;         // square the latched radius
		logic div_step;   // one restoring division step
		logic inv_wr;     // write inverse radius square
		logic issue;      // start one center/dimension pair
		logic last_d;     // pair is the last dimension of its center
		logic kill;       // empty dimension sum
		logic acc_clear;
		logic fin;        // load the output register
	} cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_busy;
	} status_t;

	// exp(-f), Q.32, truncated alternating series
	function automatic logic [63:0] exp_series(input logic [63:0] f);
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		term = 64'h1_0000_0000;
		pos  = 64'h1_0000_0000;
		neg  = 64'd0;
		for (int i = 1; i <= 15; i++) begin
			term = ((term * f) >> 32) / 64'(i);
			if ((i % 2) == 1) neg = neg + term;
			else pos = pos + term;
		end
		return pos - neg;
	endfunction

	// table entry for a Q.32 argument x
	function automatic logic [RESP_W-1:0] gauss_entry(input logic [63:0] x);
		logic [63:0] half;
		logic [63:0] e;
		logic [63:0] m;
		half = exp_series(64'h8000_0000);
		e    = exp_series(x & 64'h7FFF_FFFF);
		m    = x >> 31;
		for (int j = 0; j < 32; j++) begin
			if (64'(j) < m) e = (e * half) >> 32;
		end
		return RESP_W'((e + 64'd32768) >> 16);
	endfunction

endpackage

`default_nettype wire

// File: rtl/rbf_ctrl.sv
`default_nettype none

module rbf_ctrl #(
	parameter int MAX_CENTERS   = rbf_pkg::MAX_CENTERS_DEF,
	parameter int MAX_DIMENSION = rbf_pkg::MAX_DIMENSION_DEF,
	localparam int CIW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1,
	localparam int DAW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1,
	localparam int CCW = $clog2(MAX_CENTERS + 1),
	localparam int DCW = $clog2(MAX_DIMENSION + 1)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [0:0]                cfg_index,
	input  wire logic [rbf_pkg::NCFG_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                op,
	input  wire logic [rbf_pkg::DI_W-1:0]  di,
	input  wire logic                      last,
	input  wire rbf_pkg::status_t          status,
	output rbf_pkg::cmd_t                  cmd,
	output logic [CIW-1:0]                 j_idx,
	output logic [DAW-1:0]                 d_idx
);

	rbf_pkg::state_t state_q, state_d;
	logic [rbf_pkg::NCFG_W-1:0] ncfg_q;
	logic [rbf_pkg::DCFG_W-1:0] dcfg_q;
	logic [CCW-1:0] j_q, j_d, nc;
	logic [DAW-1:0] d_q, d_d;
	logic [DCW-1:0] nd, ndl;
	logic [4:0] cnt_q, cnt_d;
	logic accept, dim_ok, last_d, last_j;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncfg_q <= '0;
			dcfg_q <= rbf_pkg::DCFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				rbf_pkg::REG_CENTERS:   ncfg_q <= cfg_data;
				rbf_pkg::REG_DIMENSION: dcfg_q <= cfg_data[rbf_pkg::DCFG_W-1:0];
				default: ;
			endcase
		end
	end

	assign nc  = (int'(ncfg_q) > MAX_CENTERS) ? CCW'(MAX_CENTERS) : CCW'(ncfg_q);
	assign nd  = (int'(dcfg_q) > MAX_DIMENSION) ? DCW'(MAX_DIMENSION) : DCW'(dcfg_q);
	assign ndl = (nd == '0) ? DCW'(1) : nd;

	assign in_ready = (state_q == rbf_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign dim_ok   = int'(di) < MAX_DIMENSION;
	assign last_d   = (DCW'(d_q) == ndl - DCW'(1));
	assign last_j   = (j_q == nc - CCW'(1));
	assign j_idx    = j_q[CIW-1:0];
	assign d_idx    = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rbf_pkg::ST_IDLE;
			j_q     <= '0;
			d_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			j_q     <= j_d;
			d_q     <= d_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		j_d     = j_q;
		d_d     = d_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			rbf_pkg::ST_IDLE: begin
				cmd.load = accept;
				if (accept) begin
					if (op == rbf_pkg::OP_RADIUS && dim_ok) begin
						state_d = rbf_pkg::ST_SQ;
					end else if (op == rbf_pkg::OP_POINT && last) begin
						cmd.acc_clear = 1'b1;
						j_d = '0;
						d_d = '0;
						state_d = (nc == '0) ? rbf_pkg::ST_DRAIN : rbf_pkg::ST_EVAL;
					end
				end
			end
			rbf_pkg::ST_SQ: begin
				cmd.sq  = 1'b1;
				cnt_d   = '0;
				state_d = rbf_pkg::ST_DIV;
			end
			rbf_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 5'd1;
				if (cnt_q == 5'(rbf_pkg::DIV_STEPS - 1)) state_d = rbf_pkg::ST_INV;
			end
			rbf_pkg::ST_INV: begin
				cmd.inv_wr = 1'b1;
				state_d    = rbf_pkg::ST_IDLE;
			end
			rbf_pkg::ST_EVAL: begin
				cmd.issue  = 1'b1;
				cmd.last_d = last_d;
				cmd.kill   = (nd == '0);
				if (last_d) begin
					d_d = '0;
					j_d = j_q + CCW'(1);
					if (last_j) state_d = rbf_pkg::ST_DRAIN;
				end else begin
					d_d = d_q + DAW'(1);
				end
			end
			rbf_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) state_d = rbf_pkg::ST_FIN;
			end
			rbf_pkg::ST_FIN: begin
				if (!status.out_busy) begin
					cmd.fin = 1'b1;
					state_d = rbf_pkg::ST_IDLE;
				end
			end
			default: state_d = rbf_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/rbf_dpath.sv
`default_nettype none

module rbf_dpath #(
	parameter int MAX_CENTERS     = rbf_pkg::MAX_CENTERS_DEF,
	parameter int MAX_DIMENSION   = rbf_pkg::MAX_DIMENSION_DEF,
	parameter int EXP_TABLE_DEPTH = rbf_pkg::EXP_TABLE_DEPTH_DEF,
	localparam int CIW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1,
	localparam int DAW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1,
	localparam int NCD = MAX_CENTERS * MAX_DIMENSION,
	localparam int CAW = (NCD > 1) ? $clog2(NCD) : 1,
	localparam int TIW = $clog2(EXP_TABLE_DEPTH),
	localparam int AW  = 34 + $clog2(MAX_CENTERS) + 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rbf_pkg::cmd_t               cmd,
	input  wire logic [1:0]                  op,
	input  wire logic [rbf_pkg::CI_W-1:0]    ci,
	input  wire logic [rbf_pkg::DI_W-1:0]    di,
	input  wire logic [rbf_pkg::VALUE_W-1:0] value,
	input  wire logic [CIW-1:0]              j_idx,
	input  wire logic [DAW-1:0]              d_idx,
	output rbf_pkg::status_t                 status,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [rbf_pkg::PRED_W-1:0]       prediction,
	output logic                             saturated
);

	logic [rbf_pkg::VALUE_W-1:0] center_mem [NCD];
	logic [rbf_pkg::INV_W-1:0]   inv_mem [MAX_DIMENSION];
	logic [rbf_pkg::VALUE_W-1:0] weight_mem [MAX_CENTERS];
	logic [rbf_pkg::VALUE_W-1:0] point_mem [MAX_DIMENSION];
	logic [rbf_pkg::RESP_W-1:0]  gtab [EXP_TABLE_DEPTH];

	for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_tab
		localparam logic [63:0] XK = (64'(k) << 36) / EXP_TABLE_DEPTH;
		assign gtab[k] = rbf_pkg::gauss_entry(XK);
	end

	logic ci_ok, di_ok;
	assign ci_ok = int'(ci) < MAX_CENTERS;
	assign di_ok = int'(di) < MAX_DIMENSION;

	// table loads and point capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (op == rbf_pkg::OP_CENTER && ci_ok && di_ok)
				center_mem[CAW'(ci) * CAW'(MAX_DIMENSION) + CAW'(di)] <= value;
			if (op == rbf_pkg::OP_WEIGHT && ci_ok)
				weight_mem[CIW'(ci)] <= value;
			if (op == rbf_pkg::OP_POINT && di_ok)
				point_mem[DAW'(di)] <= value;
		end
	end

	// radius: square, then restoring division of 2^32 by the square
	logic [rbf_pkg::VALUE_W-1:0] rad_q;
	logic [DAW-1:0]              rdi_q;
	logic [31:0] sq_q, rem_q, rem_sh;
	logic [rbf_pkg::INV_W-1:0] quo_q;
	assign rem_sh = {rem_q[30:0], 1'b0};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rad_q <= value;
			rdi_q <= DAW'(di);
		end
		if (cmd.sq) begin
			sq_q  <= 32'($signed(rad_q) * $signed(rad_q));
			rem_q <= 32'd256;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_sh >= sq_q) begin
				rem_q <= rem_sh - sq_q;
				quo_q <= {quo_q[rbf_pkg::INV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[rbf_pkg::INV_W-2:0], 1'b0};
			end
		end
		if (cmd.inv_wr)
			inv_mem[rdi_q] <= (sq_q <= 32'd256) ? {rbf_pkg::INV_W{1'b1}} : quo_q;
	end

	// evaluation pipeline
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic l_s1, l_s2, l_s3;
	logic k_s1;
	logic [rbf_pkg::VALUE_W-1:0] c_s1, x_s1, w_s1, w_s2, w_s3, w_s4, w_s5;
	logic [rbf_pkg::INV_W-1:0]   inv_s1, inv_s2;
	logic [31:0] d2_s2;
	logic [55:0] term_s3;
	logic [63:0] z_q, zsum, z_s4;
	logic [rbf_pkg::RESP_W-1:0] resp_s5;
	logic signed [33:0] prod_s6;
	logic signed [AW-1:0] acc_q;
	logic signed [16:0] diff;
	logic [19:0] zq;
	logic [32:0] tidx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3 && l_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign diff = 17'($signed(x_s1)) - 17'($signed(c_s1));
	assign zsum = z_q + 64'(term_s3);
	assign zq   = z_s4[35:16];
	assign tidx = 33'(zq) * 33'(EXP_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		c_s1   <= center_mem[CAW'(j_idx) * CAW'(MAX_DIMENSION) + CAW'(d_idx)];
		x_s1   <= point_mem[d_idx];
		inv_s1 <= inv_mem[d_idx];
		w_s1   <= weight_mem[j_idx];
		l_s1   <= cmd.last_d;
		k_s1   <= cmd.kill;

		d2_s2  <= k_s1 ? 32'd0 : 32'(diff * diff);
		inv_s2 <= inv_s1;
		w_s2   <= w_s1;
		l_s2   <= l_s1;

		term_s3 <= 56'(d2_s2) * 56'(inv_s2);
		w_s3    <= w_s2;
		l_s3    <= l_s2;

		if (cmd.acc_clear) z_q <= '0;
		else if (v_s3) z_q <= l_s3 ? 64'd0 : zsum;
		z_s4 <= zsum;
		w_s4 <= w_s3;

		resp_s5 <= (z_s4[63:36] != '0) ? '0 : gtab[TIW'(tidx >> 20)];
		w_s5    <= w_s4;

		prod_s6 <= $signed({1'b0, resp_s5}) * $signed(w_s5);

		if (cmd.acc_clear) acc_q <= '0;
		else if (v_s6) acc_q <= acc_q + AW'(prod_s6);
	end

	assign status.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6;
	assign status.out_busy  = out_valid;

	// floor to Q16.16 and clamp
	logic signed [AW-9:0] qv;
	logic ovf;
	assign qv  = (AW-8)'(acc_q >>> 8);
	assign ovf = (qv[AW-9:31] != '0) && (qv[AW-9:31] != '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.fin) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			saturated <= ovf;
			if (!ovf) prediction <= qv[31:0];
			else if (qv[AW-9]) prediction <= 32'h8000_0000;
			else prediction <= 32'h7FFF_FFFF;
		end
	end

endmodule

`default_nettype wire

// File: rtl/rbf_network_predict.sv
// Gaussian RBF network evaluator.
// Input stream s_*: s_tuser[1:0] opcode (center component, radius, weight,
// point component), s_tdata center_index, component_index and Q8.8 value,
// s_tlast marks the last component of a query point. Output stream m_*: one
// Q16.16 prediction per query point with a saturation flag in m_tuser.
// Loads of centers, weights and point components leave the block idle and
// ready for the next item. A radius load runs a squaring step, 24 restoring
// division steps for the inverse square and a write. A point component with
// tlast starts evaluation: one center/dimension pair per cycle through a
// single multiply-accumulate pipeline, max(dimension,1) pairs per center, and
// the result goes to the result register once the pipeline has drained. No
// item is taken meanwhile.
// A result waits in the output register while m_tready is low; new loads
// are still taken, and only the next evaluation waits for it to drain.
// Configuration: cfg_index 0 centers in use, 1 dimension in use, to be written
// only while idle; the block does not enforce this. Reset clears the control
// state, configuration and valid flags only; tables hold garbage until loaded.
`default_nettype none

module rbf_network_predict #(
	parameter int MAX_CENTERS     = rbf_pkg::MAX_CENTERS_DEF,
	parameter int MAX_DIMENSION   = rbf_pkg::MAX_DIMENSION_DEF,
	parameter int EXP_TABLE_DEPTH = rbf_pkg::EXP_TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // center_index, component_index, value, zero pad
	input  wire logic [1:0]  s_tuser,   // opcode
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // prediction
	output logic [0:0]       m_tuser    // saturated
);

	localparam int CIW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
	localparam int DAW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;

	rbf_pkg::cmd_t    cmd;
	rbf_pkg::status_t status;
	logic [CIW-1:0] j_idx;
	logic [DAW-1:0] d_idx;

	rbf_ctrl #(
		.MAX_CENTERS  (MAX_CENTERS),
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.op       (s_tuser),
		.di       (s_tdata[9:6]),
		.last     (s_tlast),
		.status   (status),
		.cmd      (cmd),
		.j_idx    (j_idx),
		.d_idx    (d_idx)
	);

	rbf_dpath #(
		.MAX_CENTERS    (MAX_CENTERS),
		.MAX_DIMENSION  (MAX_DIMENSION),
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (s_tuser),
		.ci        (s_tdata[5:0]),
		.di        (s_tdata[9:6]),
		.value     (s_tdata[25:10]),
		.j_idx     (j_idx),
		.d_idx     (d_idx),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.prediction(m_tdata),
		.saturated (m_tuser[0])
	);

endmodule

`default_nettype wire

// File: sim/tb_rbf_network_predict.sv
`timescale 1ns / 100ps

module tb_rbf_network_predict;

	localparam int NCTR = 64;
	localparam int NDIM = 16;
	localparam int TAB_N = 256;
	localparam longint LIMIT = 1500000;

	class rbf_scoreboard;
		logic [15:0] ctr_mem [NCTR*NDIM];
		logic [23:0] inv_mem [NDIM];
		logic [15:0] wt_mem [NCTR];
		logic [15:0] pt_mem [NDIM];
		int unsigned ncen;
		int unsigned ndim;
		logic [31:0] pred_q [$];
		logic sat_q [$];
		longint unsigned gauss [TAB_N];
		int errors;
		int checked;

		function longint unsigned neg_exp(longint unsigned f);
			longint unsigned term, pos, neg;
			term = 64'h1_0000_0000;
			pos = term;
			neg = 0;
			for (int i = 1; i <= 15; i++) begin
				term = ((term * f) >> 32) / i;
				if (i % 2) neg += term;
				else pos += term;
			end
			return pos - neg;
		endfunction

		function new();
			longint unsigned half, x, e;
			half = neg_exp(64'h8000_0000);
			for (int k = 0; k < TAB_N; k++) begin
				x = (longint'(k) << 36) / TAB_N;
				e = neg_exp(x & 64'h7FFF_FFFF);
				for (longint unsigned m = 0; m < (x >> 31); m++) e = (e * half) >> 32;
				gauss[k] = (e + 32768) >> 16;
			end
			ncen = 0;
			ndim = 1;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(logic [0:0] idx, logic [6:0] val);
			if (idx == rbf_pkg::REG_CENTERS) ncen = val;
			else ndim = val[4:0];
		endfunction

		function int pending();
			return pred_q.size();
		endfunction

		function void note_input(logic [1:0] op, logic [5:0] ci, logic [3:0] di,
				logic [15:0] val, logic last);
			longint sq, inv, acc, q, diff, nc, nd;
			longint unsigned z, zq, resp;
			logic [31:0] p;
			logic s;
			case (op)
				rbf_pkg::OP_CENTER: ctr_mem[ci*NDIM + di] = val;
				rbf_pkg::OP_RADIUS: begin
					sq = longint'($signed(val)) * longint'($signed(val));
					inv = (sq == 0) ? 24'hFFFFFF : (64'h1_0000_0000 / sq);
					if (inv > 24'hFFFFFF) inv = 24'hFFFFFF;
					inv_mem[di] = inv[23:0];
				end
				rbf_pkg::OP_WEIGHT: wt_mem[ci] = val;
				rbf_pkg::OP_POINT: begin
					pt_mem[di] = val;
					if (last) begin
						nc = (ncen > NCTR) ? NCTR : ncen;
						nd = (ndim > NDIM) ? NDIM : ndim;
						acc = 0;
						for (int j = 0; j < nc; j++) begin
							z = 0;
							for (int d = 0; d < nd; d++) begin
								diff = longint'($signed(pt_mem[d]))
									- longint'($signed(ctr_mem[j*NDIM + d]));
								z += longint'(diff * diff) * longint'(inv_mem[d]);
							end
							zq = z >> 16;
							resp = (zq >= (64'd16 << 16)) ? 0 : gauss[(zq * TAB_N) >> 20];
							acc += longint'(resp) * longint'($signed(wt_mem[j]));
						end
						q = acc >>> 8;
						if (q > 64'sd2147483647) begin
							p = 32'h7FFF_FFFF;
							s = 1'b1;
						end else if (q < -64'sd2147483648) begin
							p = 32'h8000_0000;
							s = 1'b1;
						end else begin
							p = q[31:0];
							s = 1'b0;
						end
						pred_q = {pred_q, p};
						sat_q = {sat_q, s};
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [31:0] pred, logic sat);
			logic [31:0] ep;
			logic es;
			checked++;
			if (pred_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected prediction %h sat %b", pred, sat);
				return;
			end
			ep = pred_q.pop_front();
			es = sat_q.pop_front();
			if (pred !== ep || sat !== es) begin
				errors++;
				if (errors <= 10)
					$display("prediction mismatch: expected %h sat %b, got %h sat %b",
						ep, es, pred, sat);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [6:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic [1:0] s_tuser;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic [0:0] m_tuser;

	rbf_scoreboard sb;
	bit calm;
	longint cycles = 0;
	int items_sent;

	rbf_network_predict dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("rbf_network_predict regression: fail");
			$finish;
		end
	end

	// transfer monitors: values seen here are the ones before this edge
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_input(s_tuser, s_tdata[5:0], s_tdata[9:6], s_tdata[25:10], s_tlast);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser[0]);
	end

	always @(posedge clk) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= calm || ($urandom_range(99) >= 19);
	end

	task automatic send_item(logic [1:0] op, logic [5:0] ci, logic [3:0] di,
			logic [15:0] val, logic last);
		if (!calm && $urandom_range(99) < 19) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, val, di, ci};
		s_tlast <= last;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		// a radius load or a dropped evaluation may still be running
		repeat (1100) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [6:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	function automatic logic [15:0] any_value();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// query built near one stored center so the responses are not all zero
	task automatic near_query();
		int nc, nd, j;
		logic [15:0] v;
		nc = (sb.ncen > NCTR) ? NCTR : sb.ncen;
		nd = (sb.ndim > NDIM) ? NDIM : sb.ndim;
		j = (nc > 0) ? $urandom_range(nc - 1) : 0;
		if (nd == 0) begin
			send_item(rbf_pkg::OP_POINT, 6'($urandom_range(63)), 4'($urandom_range(15)),
				any_value(), 1'b1);
			return;
		end
		for (int d = 0; d < nd; d++) begin
			v = sb.ctr_mem[j*NDIM + d] + 16'($urandom_range(512)) - 16'd256;
			send_item(rbf_pkg::OP_POINT, 6'($urandom_range(63)), 4'(d), v, d == nd - 1);
		end
	endtask

	task automatic random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 15)
			send_item(rbf_pkg::OP_CENTER, 6'($urandom_range(63)), 4'($urandom_range(15)),
				any_value(), 1'($urandom_range(1)));
		else if (pick < 22)
			send_item(rbf_pkg::OP_RADIUS, 6'($urandom_range(63)), 4'($urandom_range(15)),
				($urandom_range(3) == 0) ? any_value() : 16'($urandom_range(64, 4096)),
				1'($urandom_range(1)));
		else if (pick < 35)
			send_item(rbf_pkg::OP_WEIGHT, 6'($urandom_range(63)), 4'($urandom_range(15)),
				any_value(), 1'($urandom_range(1)));
		else if (pick < 60)
			send_item(rbf_pkg::OP_POINT, 6'($urandom_range(63)), 4'($urandom_range(15)),
				any_value(), $urandom_range(3) == 0);
		else
			near_query();
	endtask

	initial begin
		int ncfg [8] = '{0, 1, 3, 64, 127, 5, 64, 2};
		int dcfg [8] = '{1, 0, 31, 0, 1, 16, 1, 5};
		sb = new();
		calm = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = rbf_pkg::OP_CENTER;
		s_tlast = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every entry that an evaluation reads gets written first: all centers
		// in the first component, the first five centers in every component
		for (int j = 0; j < NCTR; j++) begin
			for (int d = 0; d < ((j < 5) ? NDIM : 1); d++)
				send_item(rbf_pkg::OP_CENTER, 6'(j), 4'(d), 16'($urandom_range(16'hFFFF)),
					1'b0);
			send_item(rbf_pkg::OP_WEIGHT, 6'(j), 4'($urandom_range(15)), any_value(), 1'b0);
		end
		for (int d = 0; d < NDIM; d++) begin
			send_item(rbf_pkg::OP_RADIUS, 6'($urandom_range(63)), 4'(d),
				16'($urandom_range(256, 8192)), 1'b0);
			send_item(rbf_pkg::OP_POINT, 6'($urandom_range(63)), 4'(d),
				16'($urandom_range(16'hFFFF)), 1'b0);
		end

		// directed: extremes, zero radius, last mark on loads, empty center set
		send_item(rbf_pkg::OP_POINT, 6'd0, 4'd0, 16'h1234, 1'b1);
		drain();
		write_reg(rbf_pkg::REG_CENTERS, 7'd4);
		write_reg(rbf_pkg::REG_DIMENSION, 7'd2);
		send_item(rbf_pkg::OP_CENTER, 6'd0, 4'd0, 16'h8000, 1'b1);
		send_item(rbf_pkg::OP_CENTER, 6'd63, 4'd15, 16'h7FFF, 1'b1);
		send_item(rbf_pkg::OP_WEIGHT, 6'd63, 4'd15, 16'h8000, 1'b1);
		send_item(rbf_pkg::OP_WEIGHT, 6'd0, 4'd0, 16'h7FFF, 1'b0);
		send_item(rbf_pkg::OP_RADIUS, 6'd0, 4'd0, 16'h0000, 1'b1);
		send_item(rbf_pkg::OP_RADIUS, 6'd0, 4'd1, 16'h8000, 1'b0);
		send_item(rbf_pkg::OP_POINT, 6'd63, 4'd0, 16'h8000, 1'b0);
		send_item(rbf_pkg::OP_POINT, 6'd0, 4'd1, 16'h7FFF, 1'b1);
		send_item(rbf_pkg::OP_POINT, 6'd0, 4'd0, 16'h8000, 1'b1);
		send_item(rbf_pkg::OP_RADIUS, 6'd0, 4'd0, 16'h7FFF, 1'b0);
		send_item(rbf_pkg::OP_RADIUS, 6'd0, 4'd1, 16'h0100, 1'b0);
		near_query();
		near_query();

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(rbf_pkg::REG_CENTERS, 7'(ncfg[ph]));
			write_reg(rbf_pkg::REG_DIMENSION, 7'(dcfg[ph]));
			calm = (ph == 2);
			repeat (12) random_item();
		end
		calm = 1'b0;
		drain();

		$display("sent %0d items, checked %0d predictions over 8 register settings",
			items_sent, sb.checked);
		$display("%0d mismatches", sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("rbf_network_predict regression: pass");
		else
			$display("rbf_network_predict regression: fail");
		$finish;
	end
endmodule
